>>> hw/rtl/bounded_sequential_list_unit_defines.svh
// Assertion macros used by the checker file of the list unit.
`ifndef BOUNDED_SEQUENTIAL_LIST_UNIT_DEFINES_SVH
`define BOUNDED_SEQUENTIAL_LIST_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BSL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("list unit check failed");

// A condition that must hold whenever the trigger holds.
`define BSL_ASSERT_IMP(lbl, clk, rst_n, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error("list unit implication failed");

`endif

>>> hw/rtl/bsl_pkg.sv
package bsl_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_FIND       = 3'd4,
    OP_MODIFY     = 3'd5,
    OP_INSERT     = 3'd6,
    OP_ERASE      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e       mode;
    logic [IDX_W-1:0] pos;
  } cell_cmd_t;

endpackage

>>> hw/rtl/bsl_cell.sv
module bsl_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned DATA_W   = 32
) (
  input  logic                   clk_i,
  input  bsl_pkg::cell_cmd_t     cmd_i,
  input  logic [DATA_W-1:0]      wdata_i,
  input  logic [DATA_W-1:0]      left_i,
  input  logic [DATA_W-1:0]      right_i,
  output logic [DATA_W-1:0]      data_o,
  output logic                   match_o
);

  localparam logic [bsl_pkg::IDX_W-1:0] MyIdx = bsl_pkg::IDX_W'(CELL_IDX);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.mode)
      bsl_pkg::CELL_WRITE: begin
        if (MyIdx == cmd_i.pos) data_d = wdata_i;
      end
      bsl_pkg::CELL_INSERT: begin
        if (MyIdx == cmd_i.pos) begin
          data_d = wdata_i;
        end else if (MyIdx > cmd_i.pos) begin
          data_d = left_i;
        end
      end
      bsl_pkg::CELL_DELETE: begin
        if (MyIdx >= cmd_i.pos) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == wdata_i);

endmodule

>>> hw/rtl/bsl_ctrl.sv
module bsl_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         operation_i,
  input  logic [bsl_pkg::IDX_W-1:0]          position_i,
  input  logic [bsl_pkg::DEPTH-1:0]          match_i,
  output bsl_pkg::cell_cmd_t                 cell_cmd_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic [bsl_pkg::IDX_W-1:0]          index_o,
  output logic [bsl_pkg::CNT_W-1:0]          count_o,
  output logic                               is_empty_o
);

  logic [bsl_pkg::CNT_W-1:0] count_q;
  logic [bsl_pkg::CNT_W-1:0] count_d;
  logic                      out_valid_q;
  logic                      out_valid_d;
  bsl_pkg::status_e          status_q;
  bsl_pkg::status_e          status_d;
  logic [bsl_pkg::IDX_W-1:0] index_q;
  logic [bsl_pkg::IDX_W-1:0] index_d;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [bsl_pkg::CNT_W-1:0] pos_ext;
  logic                      found;
  logic [bsl_pkg::IDX_W-1:0] found_idx;
  logic [bsl_pkg::CNT_W-1:0] op_count;
  bsl_pkg::status_e          op_status;
  bsl_pkg::cell_cmd_t        op_cmd;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == bsl_pkg::CNT_W'(bsl_pkg::DEPTH));
  assign empty      = (count_q == '0);
  assign pos_ext    = {1'b0, position_i};

  // The lowest live entry that matches wins.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = bsl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match_i[i] && (bsl_pkg::CNT_W'(i) < count_q)) begin
        found     = 1'b1;
        found_idx = bsl_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    op_status   = bsl_pkg::ST_OK;
    op_count    = count_q;
    op_cmd.mode = bsl_pkg::CELL_HOLD;
    op_cmd.pos  = position_i;
    unique case (bsl_pkg::op_e'(operation_i))
      bsl_pkg::OP_PUSH_BACK: begin
        if (full) begin
          op_status = bsl_pkg::ST_FULL;
        end else begin
          op_cmd.mode = bsl_pkg::CELL_WRITE;
          op_cmd.pos  = count_q[bsl_pkg::IDX_W-1:0];
          op_count    = count_q + 1'b1;
        end
      end
      bsl_pkg::OP_POP_BACK: begin
        if (empty) op_status = bsl_pkg::ST_EMPTY;
        else op_count = count_q - 1'b1;
      end
      bsl_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          op_status = bsl_pkg::ST_FULL;
        end else begin
          op_cmd.mode = bsl_pkg::CELL_INSERT;
          op_cmd.pos  = '0;
          op_count    = count_q + 1'b1;
        end
      end
      bsl_pkg::OP_POP_FRONT: begin
        if (empty) begin
          op_status = bsl_pkg::ST_EMPTY;
        end else begin
          op_cmd.mode = bsl_pkg::CELL_DELETE;
          op_cmd.pos  = '0;
          op_count    = count_q - 1'b1;
        end
      end
      bsl_pkg::OP_FIND: begin
        if (!found) op_status = bsl_pkg::ST_NOT_FOUND;
      end
      bsl_pkg::OP_MODIFY: begin
        if (pos_ext >= count_q) op_status = bsl_pkg::ST_RANGE;
        else op_cmd.mode = bsl_pkg::CELL_WRITE;
      end
      bsl_pkg::OP_INSERT: begin
        if (pos_ext > count_q) begin
          op_status = bsl_pkg::ST_RANGE;
        end else if (full) begin
          op_status = bsl_pkg::ST_FULL;
        end else begin
          op_cmd.mode = bsl_pkg::CELL_INSERT;
          op_count    = count_q + 1'b1;
        end
      end
      bsl_pkg::OP_ERASE: begin
        if (empty) begin
          op_status = bsl_pkg::ST_EMPTY;
        end else if (pos_ext >= count_q) begin
          op_status = bsl_pkg::ST_RANGE;
        end else begin
          op_cmd.mode = bsl_pkg::CELL_DELETE;
          op_count    = count_q - 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    count_d     = count_q;
    status_d    = status_q;
    index_d     = index_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cell_cmd_o  = op_cmd;
    if (accept) begin
      count_d     = op_count;
      status_d    = op_status;
      index_d     = ((bsl_pkg::op_e'(operation_i) == bsl_pkg::OP_FIND) && found) ?
                    found_idx : '0;
      out_valid_d = 1'b1;
    end else begin
      cell_cmd_o.mode = bsl_pkg::CELL_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    index_q  <= index_d;
  end

  // The count register only changes on a transfer in, which also reloads
  // the result register, so it always matches the result on display.
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign index_o     = index_q;
  assign count_o     = count_q;
  assign is_empty_o  = (count_q == '0);

endmodule

>>> hw/rtl/bounded_sequential_list_unit.sv
// A result is registered and shown in the cycle after its request transfer.
// One request per cycle while no held result is refused by out_ready_i;
// every cell of the entry row shifts, writes or compares in parallel.
// The result register lets a new request in while the old result drains.
// Reset clears the entry count and the result valid; entry contents are
// undefined until written and need no clearing pass.
module bounded_sequential_list_unit #(
  parameter int unsigned DATA_W = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  index_o,
  output logic [4:0]  count_o,
  output logic        is_empty_o
);

  logic [DATA_W-1:0]          wdata;
  logic [DATA_W-1:0]          cell_data [bsl_pkg::DEPTH];
  logic [bsl_pkg::DEPTH-1:0]  match;
  bsl_pkg::cell_cmd_t         cell_cmd;

  // The stored word is the low DATA_W bits of the value, zero-extended.
  if (DATA_W > bsl_pkg::VALUE_W) begin : g_wide
    assign wdata = {{(DATA_W - bsl_pkg::VALUE_W){1'b0}}, value_i};
  end else if (DATA_W == bsl_pkg::VALUE_W) begin : g_same
    assign wdata = value_i;
  end else begin : g_narrow
    assign wdata = value_i[DATA_W-1:0];
  end

  bsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .position_i  (position_i),
    .match_i     (match),
    .cell_cmd_o  (cell_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .index_o     (index_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

  for (genvar i = 0; i < bsl_pkg::DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == bsl_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    bsl_cell #(
      .CELL_IDX (i),
      .DATA_W   (DATA_W)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .wdata_i (wdata),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

endmodule

>>> hw/rtl/bsl_checker.sv
`include "bounded_sequential_list_unit_defines.svh"

module bsl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [3:0] index_o,
  input logic [4:0] count_o,
  input logic       is_empty_o
);

  `BSL_ASSERT(a_empty_flag, clk_i, rst_ni, out_valid_o == 1'b0 || is_empty_o == (count_o == 5'd0))

  `BSL_ASSERT(a_count_bound, clk_i, rst_ni, count_o <= 5'd16)

  `BSL_ASSERT_IMP(a_index_only_ok, clk_i, rst_ni, out_valid_o && index_o != '0, status_o == bsl_pkg::ST_OK)

  `BSL_ASSERT_IMP(a_ready_when_free, clk_i, rst_ni, !out_valid_o, in_ready_o)

  `BSL_ASSERT_IMP(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o, ##1 out_valid_o)

endmodule

bind bounded_sequential_list_unit bsl_checker u_bsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .index_o     (index_o),
  .count_o     (count_o),
  .is_empty_o  (is_empty_o)
);
